[hw/rtl/fwnta_pkg.sv]
// Shared types, codes and character constants for the number-to-ASCII formatter.
package fwnta_pkg;

	// Format modes
	localparam logic [1:0] OP_UDEC = 2'd0;
	localparam logic [1:0] OP_SDEC = 2'd1;
	localparam logic [1:0] OP_HEX  = 2'd2;
	localparam logic [1:0] OP_BIN  = 2'd3;

	// Digit count limits per mode
	localparam logic [5:0] DEC_LIMIT = 6'd10;
	localparam logic [5:0] HEX_LIMIT = 6'd8;
	localparam logic [5:0] BIN_LIMIT = 6'd32;

	localparam int DEC_DIGITS = 10;
	localparam int WORD_BITS  = 32;

	localparam logic [6:0] CHAR_ZERO  = 7'h30;
	localparam logic [6:0] CHAR_A     = 7'h41;
	localparam logic [6:0] CHAR_PLUS  = 7'h2B;
	localparam logic [6:0] CHAR_MINUS = 7'h2D;
	localparam logic [3:0] DIGIT_TEN  = 4'd10;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] value;
		logic [5:0]  digit_count;
		logic [2:0]  row;
		logic [4:0]  start_column;
	} num_item_t;

	typedef struct packed {
		logic [2:0] row_out;
		logic [5:0] column_out;
		logic [6:0] char_code;
		logic       last;
	} char_item_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CONV = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	function automatic logic [6:0] digit_char(input logic [3:0] d);
		logic [6:0] c;
		if (d < DIGIT_TEN) begin
			c = CHAR_ZERO + {3'b000, d};
		end else begin
			c = CHAR_A + {3'b000, d - DIGIT_TEN};
		end
		return c;
	endfunction

endpackage

[hw/rtl/fwnta_num_if.sv]
// Valid/ready channel carrying one number to format.
interface fwnta_num_if;
	logic                  valid;
	logic                  ready;
	fwnta_pkg::num_item_t  payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

[hw/rtl/fwnta_char_if.sv]
// Valid/ready channel carrying one formatted character.
interface fwnta_char_if;
	logic                  valid;
	logic                  ready;
	fwnta_pkg::char_item_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

[hw/rtl/fixed_width_number_to_ascii.sv]
// Formats one number per transaction as fixed-width ASCII text, one character
// per output transaction, most significant digit first. Only the low digit_count
// digits are kept; signed mode leads with '+' or '-'. Hex and binary modes start
// emitting the cycle after the number is taken. Decimal modes first run a
// bit-serial shift-and-add-3 conversion, one value bit per cycle over all 32
// value bits into a ten-digit BCD register, and then emit their characters.
// Characters leave at one per cycle while the sink is ready; a new number is
// taken only after the last character of the previous one has been delivered.
module fixed_width_number_to_ascii #(
	parameter int VALUE_BITS = 32
) (
	input logic          clk,
	input logic          arst_n,
	fwnta_num_if.sink    num,
	fwnta_char_if.source text
);

	localparam int W         = fwnta_pkg::WORD_BITS;
	localparam int LIM       = (VALUE_BITS < W) ? VALUE_BITS : W;
	localparam int SIGN_BIT  = LIM - 1;
	localparam bit SIGNED_ON = (VALUE_BITS <= W);
	localparam logic [W-1:0] VMASK = {W{1'b1}} >> (W - LIM);
	localparam int CNT_BITS  = $clog2(W);
	localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(W - 1);
	localparam int ND        = fwnta_pkg::DEC_DIGITS;

	fwnta_pkg::state_t state_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                sign_pend_q;

	logic [1:0]          op_q;
	logic [5:0]          n_q;
	logic [2:0]          row_q;
	logic [5:0]          col_q;
	logic [4:0]          idx_q;
	logic                neg_q;
	logic [W-1:0]        val_q;
	logic [ND-1:0][3:0]  bcd_q;

	logic                accept;
	logic                advance;
	logic [5:0]          limit;
	logic [5:0]          n_sat;
	logic [W-1:0]        vm;
	logic                neg;
	logic [W-1:0]        mag;
	logic                is_dec;
	logic [ND-1:0][3:0]  adj;
	logic [4*ND-1:0]     adj_flat;
	logic [3:0]          digit;
	logic                last;

	assign accept  = num.valid && num.ready;
	assign advance = text.valid && text.ready;

	assign num.ready  = (state_q == fwnta_pkg::ST_IDLE);
	assign text.valid = (state_q == fwnta_pkg::ST_EMIT);

	// Input side: saturate the count, mask the value, take the magnitude
	always_comb begin
		case (num.payload.op)
			fwnta_pkg::OP_HEX: limit = fwnta_pkg::HEX_LIMIT;
			fwnta_pkg::OP_BIN: limit = fwnta_pkg::BIN_LIMIT;
			default:           limit = fwnta_pkg::DEC_LIMIT;
		endcase
		n_sat  = (num.payload.digit_count > limit) ? limit : num.payload.digit_count;
		vm     = num.payload.value & VMASK;
		neg    = (num.payload.op == fwnta_pkg::OP_SDEC) && SIGNED_ON && vm[SIGN_BIT];
		mag    = neg ? ((W'(0) - vm) & VMASK) : vm;
		is_dec = (num.payload.op == fwnta_pkg::OP_UDEC) ||
			(num.payload.op == fwnta_pkg::OP_SDEC);
	end

	// One shift-and-add-3 step; the top digit's carry falls off (mod 10^10)
	always_comb begin
		for (int k = 0; k < ND; k++) begin
			adj[k] = (bcd_q[k] >= 4'd5) ? (bcd_q[k] + 4'd3) : bcd_q[k];
		end
		adj_flat = adj;
	end

	// Output character
	always_comb begin
		case (op_q)
			fwnta_pkg::OP_HEX: digit = val_q[{idx_q[2:0], 2'b00} +: 4];
			fwnta_pkg::OP_BIN: digit = {3'b000, val_q[idx_q]};
			default:           digit = bcd_q[idx_q[3:0]];
		endcase
		last = sign_pend_q ? (n_q == 6'd0) : (idx_q == 5'd0);
		text.payload.row_out    = row_q;
		text.payload.column_out = col_q;
		text.payload.last       = last;
		if (sign_pend_q) begin
			text.payload.char_code = neg_q ? fwnta_pkg::CHAR_MINUS : fwnta_pkg::CHAR_PLUS;
		end else begin
			text.payload.char_code = fwnta_pkg::digit_char(digit);
		end
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fwnta_pkg::ST_IDLE;
			cnt_q       <= '0;
			sign_pend_q <= 1'b0;
		end else begin
			case (state_q)
				fwnta_pkg::ST_IDLE: begin
					if (accept) begin
						cnt_q       <= '0;
						sign_pend_q <= (num.payload.op == fwnta_pkg::OP_SDEC);
						if (is_dec) begin
							state_q <= fwnta_pkg::ST_CONV;
						end else if (n_sat != 6'd0) begin
							state_q <= fwnta_pkg::ST_EMIT;
						end
					end
				end
				fwnta_pkg::ST_CONV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						if (n_q == 6'd0 && !sign_pend_q) begin
							state_q <= fwnta_pkg::ST_IDLE;
						end else begin
							state_q <= fwnta_pkg::ST_EMIT;
						end
					end
				end
				fwnta_pkg::ST_EMIT: begin
					if (advance) begin
						sign_pend_q <= 1'b0;
						if (last) begin
							state_q <= fwnta_pkg::ST_IDLE;
						end
					end
				end
				default: state_q <= fwnta_pkg::ST_IDLE;
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= num.payload.op;
			n_q   <= n_sat;
			row_q <= num.payload.row;
			col_q <= {1'b0, num.payload.start_column};
			idx_q <= 5'(n_sat - 6'd1);
			neg_q <= neg;
			val_q <= mag;
			bcd_q <= '0;
		end else if (state_q == fwnta_pkg::ST_CONV) begin
			bcd_q <= {adj_flat[4*ND-2:0], val_q[W-1]};
			val_q <= {val_q[W-2:0], 1'b0};
		end else if (advance) begin
			col_q <= col_q + 6'd1;
			if (!sign_pend_q) begin
				idx_q <= idx_q - 5'd1;
			end
		end
	end

endmodule

[tb/sv/fwnta_char_scoreboard_pkg.sv]
`timescale 1ns / 1ps
// Scoreboard for the number-to-ASCII formatter: predicts characters and checks them.
package fwnta_char_scoreboard_pkg;
	import fwnta_pkg::*;

	class char_scoreboard;
		char_item_t pending_chars[$];
		int         error_count;

		function new();
			error_count = 0;
		endfunction

		function int pending();
			return pending_chars.size();
		endfunction

		// Expands one accepted number into the characters it should produce.
		function void note_number(num_item_t item);
			logic [31:0] mag;
			logic [5:0]  limit;
			logic [5:0]  count;
			logic [5:0]  col;
			logic [3:0]  digits[32];
			logic [3:0]  d;
			logic        negative;
			char_item_t  ch;
			int          i;

			mag = item.value;
			col = {1'b0, item.start_column};
			case (item.op)
				OP_HEX: limit = HEX_LIMIT;
				OP_BIN: limit = BIN_LIMIT;
				default: limit = DEC_LIMIT;
			endcase
			count = (item.digit_count > limit) ? limit : item.digit_count;

			if (item.op == OP_SDEC) begin
				negative = item.value[31];
				// -2^31 stays 0x80000000, read as unsigned below
				if (negative) begin
					mag = 32'd0 - item.value;
				end
				ch.row_out    = item.row;
				ch.column_out = col;
				ch.char_code  = negative ? CHAR_MINUS : CHAR_PLUS;
				ch.last       = (count == 6'd0);
				pending_chars.push_back(ch);
				col = col + 6'd1;
			end

			for (i = 0; i < count; i++) begin
				case (item.op)
					OP_HEX: digits[i] = mag[4 * i +: 4];
					OP_BIN: digits[i] = {3'b000, mag[i]};
					default: begin
						digits[i] = 4'(mag % 32'd10);
						mag = mag / 32'd10;
					end
				endcase
			end

			for (i = 0; i < count; i++) begin
				d = digits[count - 1 - i];
				ch.row_out    = item.row;
				ch.column_out = 6'(col + i);
				if (d < DIGIT_TEN) begin
					ch.char_code = CHAR_ZERO + {3'b000, d};
				end else begin
					ch.char_code = CHAR_A + {3'b000, d - DIGIT_TEN};
				end
				ch.last = (i + 1 == count);
				pending_chars.push_back(ch);
			end
		endfunction

		function void check_char(char_item_t got);
			char_item_t want;
			if (pending_chars.size() == 0) begin
				error_count++;
				if (error_count <= 10) begin
					$display("unexpected char: row %0d col %0d char %0d last %0d",
						got.row_out, got.column_out, got.char_code, got.last);
				end
				return;
			end
			want = pending_chars.pop_front();
			if (got.row_out != want.row_out || got.column_out != want.column_out ||
				got.char_code != want.char_code || got.last != want.last) begin
				error_count++;
				if (error_count <= 10) begin
					$display("char mismatch: expected row %0d col %0d char %0d last %0d, got row %0d col %0d char %0d last %0d",
						want.row_out, want.column_out, want.char_code, want.last,
						got.row_out, got.column_out, got.char_code, got.last);
				end
			end
		endfunction
	endclass

endpackage

[tb/sv/fixed_width_number_to_ascii_test.sv]
`timescale 1ns / 1ps
// Top-level testbench of the fixed-width number-to-ASCII formatter.
module fixed_width_number_to_ascii_test;
	import fwnta_pkg::*;
	import fwnta_char_scoreboard_pkg::*;

	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 64;
	localparam int PHASE_ITEMS    = 115;

	logic clk = 1'b0;
	logic arst_n;

	fwnta_num_if  num();
	fwnta_char_if text();

	fixed_width_number_to_ascii DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (num),
		.text   (text)
	);

	char_scoreboard sb = new();

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	bit hold_request   = 1'b0;
	bit hold_done      = 1'b0;
	int hold_left      = 0;
	int idle_cycles    = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic num_item_t make_number(logic [1:0] op, logic [31:0] value,
		logic [5:0] digit_count, logic [2:0] row, logic [4:0] start_column);
		num_item_t item;
		item.op           = op;
		item.value        = value;
		item.digit_count  = digit_count;
		item.row          = row;
		item.start_column = start_column;
		return item;
	endfunction

	task automatic send_number(input num_item_t item);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			num.valid = 1'b0;
			@(negedge clk);
		end
		num.payload = item;
		num.valid   = 1'b1;
		do @(posedge clk); while (!num.ready);
		sb.note_number(item);
	endtask

	// Receiver: random stalls, plus one long hold-off on request.
	always @(negedge clk) begin
		if (hold_request && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			text.ready = 1'b0;
		end else begin
			text.ready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && text.valid && text.ready) begin
			sb.check_char(text.payload);
		end
	end

	always @(posedge clk) begin
		if ((num.valid && num.ready) || (text.valid && text.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("fixed_width_number_to_ascii_test NOT OK");
				$finish;
			end
		end
	end

	initial begin
		num_item_t   item;
		logic [5:0]  limit;
		logic [31:0] corner[6];
		int          phase;

		corner[0] = 32'h0000_0000;
		corner[1] = 32'hFFFF_FFFF;
		corner[2] = 32'h8000_0000;
		corner[3] = 32'h7FFF_FFFF;
		corner[4] = 32'd999_999_999;
		corner[5] = 32'd1_000_000_000;

		num.valid   = 1'b0;
		num.payload = '0;
		arst_n      = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed corners
		send_number(make_number(OP_UDEC, 32'd0, 6'd1, 3'd1, 5'd1));
		send_number(make_number(OP_UDEC, 32'hFFFF_FFFF, 6'd10, 3'd4, 5'd16));
		send_number(make_number(OP_UDEC, 32'd1234567890, 6'd4, 3'd2, 5'd3));
		send_number(make_number(OP_UDEC, 32'hFFFF_FFFF, 6'd63, 3'd7, 5'd31));
		send_number(make_number(OP_UDEC, 32'd12345, 6'd0, 3'd1, 5'd1));
		send_number(make_number(OP_UDEC, 32'd9, 6'd1, 3'd2, 5'd0));
		send_number(make_number(OP_SDEC, 32'h8000_0000, 6'd10, 3'd1, 5'd1));
		send_number(make_number(OP_SDEC, 32'h7FFF_FFFF, 6'd10, 3'd3, 5'd5));
		send_number(make_number(OP_SDEC, 32'd0, 6'd3, 3'd4, 5'd16));
		send_number(make_number(OP_SDEC, 32'hFFFF_FFFF, 6'd0, 3'd2, 5'd8));
		send_number(make_number(OP_SDEC, 32'd0, 6'd0, 3'd1, 5'd2));
		send_number(make_number(OP_SDEC, 32'd5, 6'd32, 3'd6, 5'd31));
		send_number(make_number(OP_SDEC, 32'h8000_0000, 6'd1, 3'd0, 5'd0));
		send_number(make_number(OP_HEX, 32'hDEAD_BEEF, 6'd8, 3'd1, 5'd1));
		send_number(make_number(OP_HEX, 32'hFFFF_FFFF, 6'd63, 3'd4, 5'd16));
		send_number(make_number(OP_HEX, 32'hABCD_EF12, 6'd3, 3'd2, 5'd9));
		send_number(make_number(OP_HEX, 32'h1234_5678, 6'd0, 3'd3, 5'd4));
		send_number(make_number(OP_HEX, 32'd0, 6'd8, 3'd5, 5'd24));
		send_number(make_number(OP_BIN, 32'hFFFF_FFFF, 6'd32, 3'd0, 5'd0));
		send_number(make_number(OP_BIN, 32'hAAAA_AAAA, 6'd63, 3'd7, 5'd31));
		send_number(make_number(OP_BIN, 32'd5, 6'd0, 3'd1, 5'd1));
		send_number(make_number(OP_BIN, 32'd0, 6'd1, 3'd4, 5'd31));
		send_number(make_number(OP_BIN, 32'h5555_5555, 6'd33, 3'd2, 5'd16));

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
				default: begin send_idle_pct = 37; recv_stall_pct = 37; end
			endcase
			// sender keeps offering while the receiver holds off
			if (phase == 2) begin
				hold_request = 1'b1;
			end
			repeat (PHASE_ITEMS) begin
				item.op = 2'($urandom_range(3));
				case ($urandom_range(3))
					0: item.value = 32'($urandom_range(999));
					1: item.value = corner[$urandom_range(5)];
					default: item.value = $urandom();
				endcase
				case (item.op)
					OP_HEX: limit = HEX_LIMIT;
					OP_BIN: limit = BIN_LIMIT;
					default: limit = DEC_LIMIT;
				endcase
				if ($urandom_range(99) < 85) begin
					item.digit_count = 6'($urandom_range(limit, 1));
				end else begin
					item.digit_count = 6'($urandom_range(63));
				end
				if ($urandom_range(99) < 85) begin
					item.row          = 3'($urandom_range(4, 1));
					item.start_column = 5'($urandom_range(16, 1));
				end else begin
					item.row          = 3'($urandom_range(7));
					item.start_column = 5'($urandom_range(31));
				end
				send_number(item);
			end
		end

		@(negedge clk);
		num.valid = 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.error_count == 0) begin
			$display("fixed_width_number_to_ascii_test OK");
		end else begin
			$display("fixed_width_number_to_ascii_test NOT OK");
		end
		$finish;
	end

endmodule

[sim.f]
hw/rtl/fwnta_pkg.sv
hw/rtl/fwnta_num_if.sv
hw/rtl/fwnta_char_if.sv
hw/rtl/fixed_width_number_to_ascii.sv
tb/sv/fwnta_char_scoreboard_pkg.sv
tb/sv/fixed_width_number_to_ascii_test.sv
